// File: src/chmc_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
package chmc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int IDX_W        = 5;
    localparam int PROD_W       = 34;
    localparam int CW           = 60;
    localparam int ZW           = 26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_ITER,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic span;
        logic mul_px;
        logic mul_py;
        logic prep;
        logic iter;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic zero_span;
        logic special;
        logic last_step;
    } stat_t;

    // atan(2^-i) in degrees scaled by 65536, rounded to nearest.
    function automatic logic [21:0] atan_q16(input logic [IDX_W-1:0] i);
        logic [21:0] v;
        begin
            unique case (i)
                5'd0:  v = 22'd2949120;
                5'd1:  v = 22'd1740967;
                5'd2:  v = 22'd919879;
                5'd3:  v = 22'd466945;
                5'd4:  v = 22'd234379;
                5'd5:  v = 22'd117304;
                5'd6:  v = 22'd58666;
                5'd7:  v = 22'd29335;
                5'd8:  v = 22'd14668;
                5'd9:  v = 22'd7334;
                5'd10: v = 22'd3667;
                5'd11: v = 22'd1833;
                5'd12: v = 22'd917;
                5'd13: v = 22'd458;
                5'd14: v = 22'd229;
                5'd15: v = 22'd115;
                5'd16: v = 22'd57;
                5'd17: v = 22'd29;
                5'd18: v = 22'd14;
                5'd19: v = 22'd7;
                5'd20: v = 22'd4;
                5'd21: v = 22'd2;
                5'd22: v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: src/compass_heading_minmax_calibrated.sv
// Top level of the min/max calibrated compass heading block.
//
//  channel | handshake              | payload
//  input   | in_valid / in_ready    | command, mag_x, mag_y
//  output  | out_valid / out_ready  | heading_deg, heading_valid
//
// One item at a time: a sample steps through span, two products, prep and the
// iterative CORDIC loop of CORDIC_STEPS steps; clears, zero spans and exact axis
// or diagonal directions skip the loop. Reset zeroes the calibration bounds.
// A finished result waits in the output register while the next item is taken;
// the block holds its result only when a second result is ready before it leaves.
module compass_heading_minmax_calibrated (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [8:0]  heading_deg,
    output logic               heading_valid
);
    import chmc_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    chmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    chmc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (command),
        .mag_x         (mag_x),
        .mag_y         (mag_y),
        .heading_deg   (heading_deg),
        .heading_valid (heading_valid)
    );

`ifndef SYNTHESIS
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heading_valid) |-> (heading_deg != 9'd0 && heading_deg <= 9'd360))
        else $error("valid heading outside 1..360");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !heading_valid) |-> (heading_deg == 9'd0))
        else $error("invalid result with nonzero heading");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");
`endif

endmodule

// File: src/chmc_ctrl.sv
// Sequencer for the compass heading block: handshakes and step commands.
module chmc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           command,
    output logic           out_valid,
    input  logic           out_ready,
    input  chmc_pkg::stat_t stat,
    output chmc_pkg::ctrl_t ctrl
);
    import chmc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = command ? ST_FINISH : ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                ctrl.span  = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                if (stat.zero_span)
                    state_next = ST_FINISH;
                else
                begin
                    ctrl.mul_px = 1'b1;
                    state_next  = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                ctrl.mul_py = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                ctrl.prep  = 1'b1;
                state_next = stat.special ? ST_FINISH : ST_ITER;
            end
            ST_ITER:
            begin
                ctrl.iter = 1'b1;
                if (stat.last_step)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // The result register is free once the previous item has left.
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (ctrl.finish)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/chmc_dp.sv
// Datapath: calibration bounds, centering, products, CORDIC and result register.
module chmc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  chmc_pkg::ctrl_t    ctrl,
    output chmc_pkg::stat_t    stat,
    input  logic               command,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    output logic        [8:0]  heading_deg,
    output logic               heading_valid
);
    import chmc_pkg::*;

    logic signed [15:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic signed [15:0] x_reg, y_reg;
    logic               clr_reg;
    logic        [16:0] span_x_reg, span_y_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] z_reg;
    logic        [IDX_W-1:0] idx_reg;
    logic               special_reg;
    logic signed [9:0]  spec_deg_reg;
    logic        [8:0]  heading_reg;
    logic               hvalid_reg;

    // Bounds reset to zero, so the state is control-like and gets a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            x_max_reg <= '0;
            y_min_reg <= '0;
            y_max_reg <= '0;
        end
        else if (ctrl.load)
        begin
            if (command)
            begin
                x_min_reg <= '0;
                x_max_reg <= '0;
                y_min_reg <= '0;
                y_max_reg <= '0;
            end
            else
            begin
                if (mag_x < x_min_reg) x_min_reg <= mag_x;
                if (mag_x > x_max_reg) x_max_reg <= mag_x;
                if (mag_y < y_min_reg) y_min_reg <= mag_y;
                if (mag_y > y_max_reg) y_max_reg <= mag_y;
            end
        end
    end

    // Centering arithmetic.
    logic signed [16:0] sum_x, sum_y, mid_x, mid_y, sum_xc, sum_yc, dif_x, dif_y;
    always_comb
    begin
        sum_x  = 17'(x_max_reg) + 17'(x_min_reg);
        sum_y  = 17'(y_max_reg) + 17'(y_min_reg);
        // The arithmetic shift floors: bias negative sums by one first so halving truncates toward zero.
        sum_xc = sum_x + {16'd0, sum_x[16]};
        sum_yc = sum_y + {16'd0, sum_y[16]};
        mid_x  = sum_xc >>> 1;
        mid_y  = sum_yc >>> 1;
        dif_x  = 17'(x_max_reg) - 17'(x_min_reg);
        dif_y  = 17'(y_max_reg) - 17'(y_min_reg);
    end

    // One shared multiplier for both cross products.
    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [34:0] mul_p;
    always_comb
    begin
        mul_a = ctrl.mul_py ? dy_reg : dx_reg;
        mul_b = ctrl.mul_py ? $signed({1'b0, span_x_reg}) : $signed({1'b0, span_y_reg});
        mul_p = 35'(mul_a) * 35'(mul_b);
    end

    // Direct angles and quarter-turn pre-rotation.
    logic               spec;
    logic signed [9:0]  spec_deg;
    logic signed [CW-1:0] sx, sy;
    always_comb
    begin
        spec     = 1'b1;
        spec_deg = 10'sd0;
        if (py_reg == '0)
            spec_deg = px_reg[PROD_W-1] ? 10'sd180 : 10'sd0;
        else if (px_reg == '0)
            spec_deg = py_reg[PROD_W-1] ? -10'sd90 : 10'sd90;
        else if (px_reg == py_reg)
            spec_deg = px_reg[PROD_W-1] ? -10'sd135 : 10'sd45;
        else if (px_reg == -py_reg)
            spec_deg = px_reg[PROD_W-1] ? 10'sd135 : -10'sd45;
        else
            spec = 1'b0;
        sx = {{(CW-PROD_W-24){px_reg[PROD_W-1]}}, px_reg, 24'd0};
        sy = {{(CW-PROD_W-24){py_reg[PROD_W-1]}}, py_reg, 24'd0};
    end

    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] az;
    always_comb
    begin
        xs = cx_reg >>> idx_reg;
        ys = cy_reg >>> idx_reg;
        az = $signed({4'd0, atan_q16(idx_reg)});
    end

    // Angle truncated toward zero, then folded into 1..360.
    logic signed [9:0] zdeg, deg;
    logic        [9:0] deg_pos;
    always_comb
    begin
        zdeg = z_reg[ZW-1:16];
        if (z_reg[ZW-1] && (z_reg[15:0] != 16'd0))
            zdeg = zdeg + 10'sd1;
        deg     = special_reg ? spec_deg_reg : zdeg;
        deg_pos = (deg <= 10'sd0) ? 10'(deg + 10'sd360) : 10'(deg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg       <= mag_x;
            y_reg       <= mag_y;
            clr_reg     <= command;
            special_reg <= 1'b0;
        end
        if (ctrl.span)
        begin
            span_x_reg <= dif_x;
            span_y_reg <= dif_y;
            dx_reg     <= 17'(x_reg) - mid_x;
            dy_reg     <= 17'(y_reg) - mid_y;
        end
        if (ctrl.mul_px)
            px_reg <= mul_p[PROD_W-1:0];
        if (ctrl.mul_py)
            py_reg <= mul_p[PROD_W-1:0];
        if (ctrl.prep)
        begin
            special_reg  <= spec;
            spec_deg_reg <= spec_deg;
            idx_reg      <= '0;
            if (sx[CW-1])
            begin
                if (!sy[CW-1])
                begin
                    cx_reg <= sy;
                    cy_reg <= -sx;
                    z_reg  <= ZW'(90 * 65536);
                end
                else
                begin
                    cx_reg <= -sy;
                    cy_reg <= sx;
                    z_reg  <= -ZW'(90 * 65536);
                end
            end
            else
            begin
                cx_reg <= sx;
                cy_reg <= sy;
                z_reg  <= '0;
            end
        end
        if (ctrl.iter)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!cy_reg[CW-1])
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                z_reg  <= z_reg + az;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                z_reg  <= z_reg - az;
            end
        end
        if (ctrl.finish)
        begin
            if (clr_reg || (span_x_reg == '0) || (span_y_reg == '0))
            begin
                heading_reg <= '0;
                hvalid_reg  <= 1'b0;
            end
            else
            begin
                heading_reg <= deg_pos[8:0];
                hvalid_reg  <= 1'b1;
            end
        end
    end

    assign stat.zero_span = (span_x_reg == '0) || (span_y_reg == '0);
    assign stat.special   = spec;
    assign stat.last_step = (idx_reg == IDX_W'(CORDIC_STEPS - 1));
    assign heading_deg    = heading_reg;
    assign heading_valid  = hvalid_reg;

endmodule
